>>> design/lsws_pkg.sv
// Shared types and constants for the LIFO stack with search.
// Used by lifo_stack_with_search_unit and its testbench; depends on nothing else.
package lsws_pkg;

    localparam int VALUE_W   = 32;
    localparam int FUNC_W    = 3;
    localparam int STATUS_W  = 2;
    localparam int NODE_W    = 16;
    localparam int POS_W     = 4;
    localparam int COUNT_W   = 5;

    localparam int DEPTH_DEF   = 16;
    localparam int ID_BITS_DEF = 16;

    localparam logic [FUNC_W-1:0] FUNC_PUSH   = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_POP    = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_PEEK   = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_SEARCH = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 3'd4;

    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY     = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SEARCH
    } t_state;

    typedef struct packed {
        logic [FUNC_W-1:0]         func;
        logic signed [VALUE_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic signed [VALUE_W-1:0] entry_value;
        logic [NODE_W-1:0]         node_id;
        logic [POS_W-1:0]          position;
        logic                      hit;
        logic [COUNT_W-1:0]        count;
        logic                      last;
    } t_result;

endpackage

>>> design/lsws_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// Standalone; instanced by lifo_stack_with_search_unit.
module lsws_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/lifo_stack_with_search_unit.sv
// Top level of the LIFO stack with search: control sequencer around one stack RAM.
// Depends on lsws_pkg and lsws_ram.
//
// Push and clear leave the unit idle, so the next item may follow at once.
// Pop and peek pass through the read state, because the top entry comes out
// of the stack RAM in the cycle after its address is presented; busy is high
// for one cycle. Search walks the entries from the top down after a first RAM
// read, and busy falls in the cycle that carries the strobe of the last
// result. An empty-stack pop, peek or search answers without leaving the idle
// state. Items with func codes zero to four yield their results as one-cycle
// strobes on o_strobe, each in the cycle after it is formed; the receiver
// cannot stall them. Func codes five to seven are ignored and produce no result.
module lifo_stack_with_search_unit #(
    parameter int DEPTH   = lsws_pkg::DEPTH_DEF,
    parameter int ID_BITS = lsws_pkg::ID_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  lsws_pkg::t_in_item i_item,
    output logic              o_busy,
    output logic              o_strobe,
    output lsws_pkg::t_result  o_result
);

    localparam int AW     = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int MEM_W  = lsws_pkg::VALUE_W + ID_BITS;
    localparam int CEXT_W = CNT_W + lsws_pkg::COUNT_W;
    localparam int IEXT_W = ID_BITS + lsws_pkg::NODE_W;

    lsws_pkg::t_state r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [ID_BITS-1:0] r_id, n_id;
    logic               r_strobe, n_strobe;
    lsws_pkg::t_result  r_result, n_result;
    logic [AW-1:0]      r_idx, n_idx;
    logic [lsws_pkg::POS_W-1:0] r_pos, n_pos;
    logic signed [lsws_pkg::VALUE_W-1:0] r_key, n_key;
    logic               r_pop, n_pop;

    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [MEM_W-1:0]   mem_wdata;
    logic [AW-1:0]      mem_raddr;
    logic [MEM_W-1:0]   mem_rdata;

    logic               accept;
    logic [CNT_W-1:0]   cnt_m1;
    logic [CEXT_W-1:0]  cnt_ext;
    logic [CEXT_W-1:0]  cnt_m1_ext;
    logic [IEXT_W-1:0]  id_ext;
    logic [IEXT_W-1:0]  rd_id_ext;
    logic signed [lsws_pkg::VALUE_W-1:0] rd_value;
    logic               rd_hit;
    logic               rd_bottom;

    lsws_ram #(
        .WIDTH (MEM_W),
        .DEPTH (DEPTH)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign accept     = i_start && (r_state == lsws_pkg::ST_IDLE);
    assign cnt_m1     = r_count - 1'b1;
    assign cnt_ext    = CEXT_W'(r_count);
    assign cnt_m1_ext = CEXT_W'(cnt_m1);
    assign id_ext     = IEXT_W'(r_id);
    assign rd_value   = mem_rdata[MEM_W-1:ID_BITS];
    assign rd_id_ext  = IEXT_W'(mem_rdata[ID_BITS-1:0]);
    assign rd_hit     = (rd_value == r_key);
    assign rd_bottom  = (r_idx == '0);

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_id      = r_id;
        n_strobe  = 1'b0;
        n_result  = '0;
        n_idx     = r_idx;
        n_pos     = r_pos;
        n_key     = r_key;
        n_pop     = r_pop;
        mem_we    = 1'b0;
        mem_waddr = r_count[AW-1:0];
        mem_wdata = {i_item.value, r_id};
        mem_raddr = cnt_m1[AW-1:0];

        unique case (r_state)
            lsws_pkg::ST_IDLE: begin
                if (accept) begin
                    n_result.count = cnt_ext[lsws_pkg::COUNT_W-1:0];
                    n_result.last  = 1'b1;
                    unique case (i_item.func)
                        lsws_pkg::FUNC_PUSH: begin
                            n_strobe = 1'b1;
                            n_result.entry_value = i_item.value;
                            if (r_count == CNT_W'(DEPTH)) begin
                                n_result.status = lsws_pkg::STAT_FULL;
                            end else begin
                                mem_we          = 1'b1;
                                n_count         = r_count + 1'b1;
                                n_id            = r_id + 1'b1;
                                n_result.status = lsws_pkg::STAT_OK;
                                n_result.node_id = id_ext[lsws_pkg::NODE_W-1:0];
                                n_result.count  = cnt_ext[lsws_pkg::COUNT_W-1:0] + 1'b1;
                            end
                        end
                        lsws_pkg::FUNC_POP, lsws_pkg::FUNC_PEEK: begin
                            if (r_count == '0) begin
                                n_strobe        = 1'b1;
                                n_result.status = lsws_pkg::STAT_EMPTY;
                            end else begin
                                n_pop   = (i_item.func == lsws_pkg::FUNC_POP);
                                n_state = lsws_pkg::ST_READ;
                            end
                        end
                        lsws_pkg::FUNC_SEARCH: begin
                            if (r_count == '0) begin
                                n_strobe        = 1'b1;
                                n_result.status = lsws_pkg::STAT_NOT_FOUND;
                            end else begin
                                n_key   = i_item.value;
                                n_idx   = cnt_m1[AW-1:0];
                                n_pos   = '0;
                                n_state = lsws_pkg::ST_SEARCH;
                            end
                        end
                        lsws_pkg::FUNC_CLEAR: begin
                            n_strobe        = 1'b1;
                            n_count         = '0;
                            n_result.status = lsws_pkg::STAT_OK;
                            n_result.count  = '0;
                        end
                        default: begin
                            n_result = '0;
                        end
                    endcase
                end
            end
            lsws_pkg::ST_READ: begin
                // The top entry's data arrived from the RAM this cycle.
                n_strobe             = 1'b1;
                n_result.status      = lsws_pkg::STAT_OK;
                n_result.entry_value = rd_value;
                n_result.node_id     = rd_id_ext[lsws_pkg::NODE_W-1:0];
                n_result.last        = 1'b1;
                if (r_pop) begin
                    n_count        = cnt_m1;
                    n_result.count = cnt_m1_ext[lsws_pkg::COUNT_W-1:0];
                end else begin
                    n_result.count = cnt_ext[lsws_pkg::COUNT_W-1:0];
                end
                n_state = lsws_pkg::ST_IDLE;
            end
            lsws_pkg::ST_SEARCH: begin
                // Report the entry read last cycle while fetching the one below it.
                n_strobe             = 1'b1;
                n_result.status      = (!rd_hit && rd_bottom) ? lsws_pkg::STAT_NOT_FOUND
                                                              : lsws_pkg::STAT_OK;
                n_result.entry_value = rd_value;
                n_result.node_id     = rd_id_ext[lsws_pkg::NODE_W-1:0];
                n_result.position    = r_pos;
                n_result.hit         = rd_hit;
                n_result.count       = cnt_ext[lsws_pkg::COUNT_W-1:0];
                n_result.last        = rd_hit || rd_bottom;
                mem_raddr            = r_idx - 1'b1;
                if (rd_hit || rd_bottom) begin
                    n_state = lsws_pkg::ST_IDLE;
                end else begin
                    n_idx = r_idx - 1'b1;
                    n_pos = r_pos + 1'b1;
                end
            end
            default: begin
                n_state = lsws_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= lsws_pkg::ST_IDLE;
            r_count  <= '0;
            r_id     <= '0;
            r_strobe <= 1'b0;
            r_pop    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_id     <= n_id;
            r_strobe <= n_strobe;
            r_pop    <= n_pop;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
        r_idx    <= n_idx;
        r_pos    <= n_pos;
        r_key    <= n_key;
    end

    assign o_busy   = (r_state != lsws_pkg::ST_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for lifo_stack_with_search_unit: drives push, pop, peek, search,
// clear and ignored codes, and checks every result strobe against a shadow copy of the stack.
// Depends on lsws_pkg and the RTL of the unit.
module testbench;

    class stack_scoreboard;
        logic signed [lsws_pkg::VALUE_W-1:0] shadow_value [lsws_pkg::DEPTH_DEF];
        logic [lsws_pkg::NODE_W-1:0]         shadow_id [lsws_pkg::DEPTH_DEF];
        int                                  shadow_count;
        logic [lsws_pkg::NODE_W-1:0]         next_node_id;
        lsws_pkg::t_result                   pending_results [$];
        int                                  errors;

        function new();
            shadow_count = 0;
            next_node_id = '0;
            errors       = 0;
        endfunction

        function int pending_count();
            return pending_results.size();
        endfunction

        function void queue_result(lsws_pkg::t_result r);
            pending_results = {pending_results, r};
        endfunction

        // Works out every result that one accepted item causes and queues them in order.
        function void note_item(lsws_pkg::t_in_item item);
            lsws_pkg::t_result r;
            int      i;
            int      idx;
            bit      match;
            r = '0;
            r.last = 1'b1;
            case (item.func)
                lsws_pkg::FUNC_PUSH: begin
                    if (shadow_count >= lsws_pkg::DEPTH_DEF) begin
                        r.status      = lsws_pkg::STAT_FULL;
                        r.entry_value = item.value;
                    end else begin
                        shadow_value[shadow_count] = item.value;
                        shadow_id[shadow_count]    = next_node_id;
                        shadow_count++;
                        r.status      = lsws_pkg::STAT_OK;
                        r.entry_value = item.value;
                        r.node_id     = next_node_id;
                        next_node_id  = next_node_id + 1'b1;
                    end
                    r.count = shadow_count[lsws_pkg::COUNT_W-1:0];
                    queue_result(r);
                end
                lsws_pkg::FUNC_POP, lsws_pkg::FUNC_PEEK: begin
                    if (shadow_count == 0) begin
                        r.status = lsws_pkg::STAT_EMPTY;
                    end else begin
                        r.status      = lsws_pkg::STAT_OK;
                        r.entry_value = shadow_value[shadow_count-1];
                        r.node_id     = shadow_id[shadow_count-1];
                        if (item.func == lsws_pkg::FUNC_POP)
                            shadow_count--;
                    end
                    r.count = shadow_count[lsws_pkg::COUNT_W-1:0];
                    queue_result(r);
                end
                lsws_pkg::FUNC_SEARCH: begin
                    if (shadow_count == 0) begin
                        r.status = lsws_pkg::STAT_NOT_FOUND;
                        queue_result(r);
                    end else begin
                        // Walk from the top down; stop at the first match or at the bottom.
                        for (i = 0; i < shadow_count; i++) begin
                            idx   = shadow_count - 1 - i;
                            match = (shadow_value[idx] == item.value);
                            r.status      = (!match && idx == 0) ? lsws_pkg::STAT_NOT_FOUND
                                                                 : lsws_pkg::STAT_OK;
                            r.entry_value = shadow_value[idx];
                            r.node_id     = shadow_id[idx];
                            r.position    = i[lsws_pkg::POS_W-1:0];
                            r.hit         = match;
                            r.count       = shadow_count[lsws_pkg::COUNT_W-1:0];
                            r.last        = match || (idx == 0);
                            queue_result(r);
                            if (match)
                                break;
                        end
                    end
                end
                lsws_pkg::FUNC_CLEAR: begin
                    shadow_count = 0;
                    r.status = lsws_pkg::STAT_OK;
                    queue_result(r);
                end
                default: begin
                    // Unused codes leave the stack alone and answer nothing.
                end
            endcase
        endfunction

        function void compare_field(string name, longint want, longint got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(lsws_pkg::t_result got);
            lsws_pkg::t_result want;
            if (pending_results.size() == 0) begin
                $error("result strobe with no result outstanding: %h", got);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if ($isunknown(got)) begin
                $error("result has unknown bits: %h", got);
                errors++;
            end
            compare_field("status", want.status, got.status);
            compare_field("entry_value", want.entry_value, got.entry_value);
            compare_field("node_id", want.node_id, got.node_id);
            compare_field("position", want.position, got.position);
            compare_field("hit", want.hit, got.hit);
            compare_field("count", want.count, got.count);
            compare_field("last", want.last, got.last);
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_start;
    lsws_pkg::t_in_item  i_item;
    logic                o_busy;
    logic                o_strobe;
    lsws_pkg::t_result   o_result;

    stack_scoreboard                     board;
    int                                  sender_idle_pct;
    logic signed [lsws_pkg::VALUE_W-1:0] value_pool [8];

    lifo_stack_with_search_unit u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_item   (i_item),
        .o_busy   (o_busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    always #4 i_clk = ~i_clk;

    // An item counts as taken before any result of the same edge is checked.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (i_start && o_busy === 1'b0)
                board.note_item(i_item);
            if (o_strobe === 1'b1)
                board.check_result(o_result);
        end
    end

    task automatic send_item(input logic [lsws_pkg::FUNC_W-1:0] func,
                             input logic signed [lsws_pkg::VALUE_W-1:0] value);
        lsws_pkg::t_in_item item;
        item.func  = func;
        item.value = value;
        i_start <= 1'b1;
        i_item  <= item;
        do @(posedge i_clk); while (o_busy !== 1'b0);
        if ($urandom_range(0, 99) < sender_idle_pct) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        i_start <= 1'b0;
        while (board.pending_count() != 0)
            @(posedge i_clk);
    endtask

    // Mostly values from a small pool so that searches hit and duplicates occur.
    function automatic logic signed [lsws_pkg::VALUE_W-1:0] pick_value();
        if ($urandom_range(0, 99) < 70)
            return value_pool[$urandom_range(0, 7)];
        return $urandom;
    endfunction

    task automatic send_random_item();
        int roll;
        int code;
        roll = $urandom_range(0, 99);
        code = $urandom_range(5, 7);
        if (roll < 40)
            send_item(lsws_pkg::FUNC_PUSH, pick_value());
        else if (roll < 52)
            send_item(lsws_pkg::FUNC_POP, $urandom);
        else if (roll < 60)
            send_item(lsws_pkg::FUNC_PEEK, $urandom);
        else if (roll < 88)
            send_item(lsws_pkg::FUNC_SEARCH, pick_value());
        else if (roll < 93)
            send_item(lsws_pkg::FUNC_CLEAR, $urandom);
        else
            send_item(code[lsws_pkg::FUNC_W-1:0], $urandom);
    endtask

    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        int phase;
        int n;
        board = new();
        value_pool[0] = 32'sh7FFF_FFFF;
        value_pool[1] = 32'sh8000_0000;
        value_pool[2] = '0;
        value_pool[3] = -1;
        for (n = 4; n < 8; n++)
            value_pool[n] = $urandom;
        sender_idle_pct = 23;
        i_rst_n <= 1'b0;
        i_start <= 1'b0;
        i_item  <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty-stack answers, field extremes, every operation and the ignored codes.
        send_item(lsws_pkg::FUNC_POP, 32'sh1357_9BDF);
        send_item(lsws_pkg::FUNC_PEEK, -1);
        send_item(lsws_pkg::FUNC_SEARCH, '0);
        send_item(lsws_pkg::FUNC_PUSH, 32'sh7FFF_FFFF);
        send_item(lsws_pkg::FUNC_PUSH, 32'sh8000_0000);
        send_item(lsws_pkg::FUNC_PUSH, -1);
        send_item(lsws_pkg::FUNC_PUSH, '0);
        send_item(lsws_pkg::FUNC_PEEK, '0);
        send_item(lsws_pkg::FUNC_SEARCH, 32'sh7FFF_FFFF);
        send_item(lsws_pkg::FUNC_SEARCH, 32'sh8000_0000);
        send_item(lsws_pkg::FUNC_SEARCH, 32'sh0BAD_F00D);
        send_item(lsws_pkg::FUNC_POP, '0);
        send_item(3'd5, 32'sh8000_0000);
        send_item(3'd6, -1);
        send_item(3'd7, 32'sh7FFF_FFFF);
        send_item(lsws_pkg::FUNC_CLEAR, -1);
        send_item(lsws_pkg::FUNC_PEEK, '0);
        drain_results();

        for (phase = 0; phase < 3; phase++) begin
            sender_idle_pct = (phase == 0) ? 23 : (phase == 1) ? 81 : 0;
            if (phase == 1) begin
                // Fill past the top so a push is refused, then search the whole depth.
                send_item(lsws_pkg::FUNC_CLEAR, $urandom);
                for (n = 0; n <= lsws_pkg::DEPTH_DEF; n++)
                    send_item(lsws_pkg::FUNC_PUSH, value_pool[$urandom_range(0, 7)]);
                send_item(lsws_pkg::FUNC_SEARCH, 32'sh1234_5678);
                send_item(lsws_pkg::FUNC_SEARCH, value_pool[$urandom_range(0, 7)]);
            end
            for (n = 0; n < 31; n++)
                send_random_item();
            if (phase == 0)
                drain_results();
        end

        drain_results();
        repeat (24) @(posedge i_clk);
        if (board.errors == 0 && board.pending_count() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

>>> lifo_stack_with_search_unit.f
design/lsws_pkg.sv
design/lsws_ram.sv
design/lifo_stack_with_search_unit.sv
dv/testbench.sv
